// ===== rtl/hsmmi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the max/min interleaving heap sorter.
// Depends on nothing; every other file of the block imports it.
package hsmmi_pkg;

    // Batch capacity and the widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Child indices can reach 2*(CAPACITY-1)+2, so they need two bits more than an address.
    localparam int IDX_W    = ADDR_W + 2;

    // One input beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     batch_end;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     final_res;
        logic                     overflow;
    } t_out_item;

    // Access to the element store: one write and one read port.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Result offered by the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_emit;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_NEXT,
        S_RD_X,
        S_LD_X,
        S_RD_L,
        S_RD_R,
        S_PICK,
        S_PLACE,
        S_SORT_NEXT,
        S_SORT_RD0,
        S_SORT_RDI,
        S_SORT_SWAP,
        S_EMIT_RD,
        S_EMIT_WAIT
    } t_state;

endpackage

// ===== rtl/hsmmi_store.sv =====
`timescale 1ns / 1ps
// Element store: single-port-write, single-port-read memory with registered read data.
// Depends on hsmmi_pkg for widths and the request struct.
module hsmmi_store
    import hsmmi_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    // Write and registered read; a read sees writes of earlier cycles.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hsmmi_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the heap sorter: batch loading, sift-down with one shared comparator,
// the sort passes and the interleaved read-out. Depends on hsmmi_pkg.
module hsmmi_seq
    import hsmmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_stall,
    output t_mem_req          o_req,
    input  logic [DATA_W-1:0] i_rdata,
    output t_emit             o_emit,
    input  logic              i_emit_take
);

    // Control state.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_dropped, n_dropped;

    // Loop counters and sift registers.
    logic [CNT_W-1:0]  r_bi, n_bi;
    logic [CNT_W-1:0]  r_si, n_si;
    logic [CNT_W-1:0]  r_size, n_size;
    logic              r_sorting, n_sorting;
    logic [ADDR_W-1:0] r_root, n_root;
    logic [ADDR_W-1:0] r_ci, n_ci;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_lv, n_lv;
    logic [DATA_W-1:0] r_cv, n_cv;
    logic [DATA_W-1:0] r_top, n_top;
    logic [ADDR_W-1:0] r_lo, n_lo;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic              r_side, n_side;

    logic              w_accept;
    logic              w_room;
    logic [CNT_W-1:0]  w_count_acc;
    logic [CNT_W-1:0]  w_bi_m1;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [IDX_W-1:0]  w_l;
    logic [IDX_W-1:0]  w_r;
    logic [IDX_W-1:0]  w_size_x;
    logic              w_l_ok;
    logic              w_r_ok;
    logic [DATA_W-1:0] w_cmp_a;
    logic [DATA_W-1:0] w_cmp_b;
    logic              w_gt;
    logic              w_final;
    t_state            w_done_state;

    // Handshake and batch bookkeeping.
    assign o_in_stall  = (r_state != S_LOAD);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_room      = (r_count < CNT_W'(CAPACITY));
    assign w_count_acc = r_count + CNT_W'(w_room);
    assign w_bi_m1     = r_bi - 1'b1;
    assign w_cnt_m1    = r_count - 1'b1;

    // Child indices of the current root and their bounds check.
    assign w_l      = {1'b0, r_root, 1'b1};
    assign w_r      = w_l + 1'b1;
    assign w_size_x = IDX_W'(r_size);
    assign w_l_ok   = (w_l < w_size_x);
    assign w_r_ok   = (w_r < w_size_x);

    // The one comparator: right child against left, then chosen child against the sifted value.
    always_comb begin
        if (r_state == S_PICK) begin
            w_cmp_a = i_rdata;
            w_cmp_b = r_lv;
        end else begin
            w_cmp_a = r_cv;
            w_cmp_b = r_x;
        end
    end
    assign w_gt = ($signed(w_cmp_a) > $signed(w_cmp_b));

    // Last result: the odd middle on the high side, or the low side meeting the high side.
    assign w_final = r_side ? ((ADDR_W + 1)'(r_lo) + 1'b1 == (ADDR_W + 1)'(r_hi))
                            : (r_lo == r_hi);

    assign w_done_state = r_sorting ? S_SORT_NEXT : S_BUILD_NEXT;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_in_data.batch_end) begin
                    n_state = S_BUILD_NEXT;
                end
            end
            S_BUILD_NEXT: n_state = (r_bi == '0) ? S_SORT_NEXT : S_RD_X;
            S_RD_X:       n_state = S_LD_X;
            S_LD_X:       n_state = S_RD_L;
            S_RD_L:       n_state = w_l_ok ? S_RD_R : w_done_state;
            S_RD_R:       n_state = S_PICK;
            S_PICK:       n_state = S_PLACE;
            S_PLACE:      n_state = w_gt ? S_RD_L : w_done_state;
            S_SORT_NEXT:  n_state = (r_si == '0) ? S_EMIT_RD : S_SORT_RD0;
            S_SORT_RD0:   n_state = S_SORT_RDI;
            S_SORT_RDI:   n_state = S_SORT_SWAP;
            S_SORT_SWAP:  n_state = S_RD_L;
            S_EMIT_RD:    n_state = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (i_emit_take) begin
                    n_state = w_final ? S_LOAD : S_EMIT_RD;
                end
            end
            default:      n_state = S_LOAD;
        endcase
    end

    // Memory requests and the offered result.
    always_comb begin
        o_req.we    = 1'b0;
        o_req.waddr = r_root;
        o_req.wdata = r_x;
        o_req.raddr = '0;
        case (r_state)
            S_LOAD: begin
                o_req.we    = w_accept && w_room;
                o_req.waddr = r_count[ADDR_W-1:0];
                o_req.wdata = i_in_data.value;
            end
            S_RD_X: o_req.raddr = r_root;
            S_RD_L: begin
                // A leaf: the sifted value settles here.
                o_req.we    = !w_l_ok;
                o_req.raddr = w_l[ADDR_W-1:0];
            end
            S_RD_R: o_req.raddr = w_r[ADDR_W-1:0];
            S_PLACE: begin
                o_req.we    = 1'b1;
                o_req.wdata = w_gt ? r_cv : r_x;
            end
            S_SORT_RDI: o_req.raddr = r_si[ADDR_W-1:0];
            S_SORT_SWAP: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_si[ADDR_W-1:0];
                o_req.wdata = r_top;
            end
            S_EMIT_RD, S_EMIT_WAIT: o_req.raddr = r_side ? r_lo : r_hi;
            default: o_req.raddr = '0;
        endcase
    end

    assign o_emit.valid          = (r_state == S_EMIT_WAIT);
    assign o_emit.item.value_res = i_rdata;
    assign o_emit.item.final_res = w_final;
    assign o_emit.item.overflow  = r_dropped;

    // Next values of the counters and data registers.
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_bi      = r_bi;
        n_si      = r_si;
        n_size    = r_size;
        n_sorting = r_sorting;
        n_root    = r_root;
        n_ci      = r_ci;
        n_x       = r_x;
        n_lv      = r_lv;
        n_cv      = r_cv;
        n_top     = r_top;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_side    = r_side;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    n_count = w_count_acc;
                    if (!w_room) begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_data.batch_end) begin
                        n_bi      = w_count_acc >> 1;
                        n_size    = w_count_acc;
                        n_sorting = 1'b0;
                    end
                end
            end
            S_BUILD_NEXT: begin
                if (r_bi == '0) begin
                    n_sorting = 1'b1;
                    n_si      = w_cnt_m1;
                end else begin
                    n_bi   = w_bi_m1;
                    n_root = w_bi_m1[ADDR_W-1:0];
                end
            end
            S_LD_X: n_x  = i_rdata;
            S_RD_R: n_lv = i_rdata;
            S_PICK: begin
                if (w_r_ok && w_gt) begin
                    n_cv = i_rdata;
                    n_ci = w_r[ADDR_W-1:0];
                end else begin
                    n_cv = r_lv;
                    n_ci = w_l[ADDR_W-1:0];
                end
            end
            S_PLACE: begin
                if (w_gt) begin
                    n_root = r_ci;
                end
            end
            S_SORT_NEXT: begin
                if (r_si == '0) begin
                    n_lo   = '0;
                    n_hi   = w_cnt_m1[ADDR_W-1:0];
                    n_side = 1'b0;
                end
            end
            S_SORT_RDI: n_top = i_rdata;
            S_SORT_SWAP: begin
                // The old last element becomes the value sifted down from the root.
                n_x    = i_rdata;
                n_root = '0;
                n_size = r_si;
                n_si   = r_si - 1'b1;
            end
            S_EMIT_WAIT: begin
                if (i_emit_take) begin
                    if (w_final) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                    end else if (!r_side) begin
                        n_side = 1'b1;
                    end else begin
                        n_side = 1'b0;
                        n_lo   = r_lo + 1'b1;
                        n_hi   = r_hi - 1'b1;
                    end
                end
            end
            default: n_count = r_count;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_bi      <= n_bi;
        r_si      <= n_si;
        r_size    <= n_size;
        r_sorting <= n_sorting;
        r_root    <= n_root;
        r_ci      <= n_ci;
        r_x       <= n_x;
        r_lv      <= n_lv;
        r_cv      <= n_cv;
        r_top     <= n_top;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_side    <= n_side;
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    a_root_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_L) |-> (CNT_W'(r_root) < r_size))
        else $error("sift root outside the heap");

    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_WAIT) |-> (r_lo <= r_hi))
        else $error("read-out pointers crossed");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit_take && w_final) |=> (r_state == S_LOAD && r_count == '0 && !r_dropped))
        else $error("batch not cleared after its last result");
`endif

endmodule

// ===== rtl/heap_sort_max_min_interleave.sv =====
`timescale 1ns / 1ps
// Top level of the max/min interleaving heap sorter: sequencer, element store and
// the output register. Depends on hsmmi_pkg, hsmmi_store and hsmmi_seq.
//
// The block takes one element beat per cycle until a beat with batch_end set, storing up to
// CAPACITY elements and dropping the rest. From the closing beat on, the input is stalled while
// the batch of n elements is heap-sorted in place: every level of a sift-down takes the states
// S_RD_L, S_RD_R, S_PICK and S_PLACE on the single read port of the element store, after the
// set-up states of its sift. The results then leave one beat at a time, each read from the store
// and held until the output register takes it: largest, smallest, second largest and so on, with
// the last beat marked and overflow set on every beat of a batch that lost elements. The input
// opens again as soon as the last result has entered the output register.
module heap_sort_max_min_interleave
    import hsmmi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_mem_req          w_req;
    logic [DATA_W-1:0] w_rdata;
    t_emit             w_emit;
    logic              w_take;
    logic              r_ovalid;
    t_out_item         r_odata;

    hsmmi_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_req       (w_req),
        .i_rdata     (w_rdata),
        .o_emit      (w_emit),
        .i_emit_take (w_take)
    );

    hsmmi_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // A result moves into the output register when it is empty or its beat leaves.
    assign w_take = w_emit.valid && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_odata <= w_emit.item;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
